@@ sv/quorum_commit_seq_select_assert.svh @@
// Assertion macros used by the checker file.
`ifndef QUORUM_COMMIT_SEQ_SELECT_ASSERT_SVH
`define QUORUM_COMMIT_SEQ_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QCSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define QCSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/qcss_pkg.sv @@
// Package with shared types and constants of the quorum sequence selector.
package qcss_pkg;

    localparam int SEQ_W            = 63;
    localparam int SLOT_W           = 3;
    localparam int KIND_W           = 2;
    localparam int QSIZE_W          = 5;
    localparam int NEED_W           = 4;
    localparam int CNT_OUT_W        = 4;
    localparam int MAX_REPLICAS_DEF = 8;
    localparam int CQ_DEPTH         = 2;
    localparam logic [QSIZE_W-1:0] QSIZE_RESET = 5'd3;

    typedef enum logic [KIND_W-1:0] {
        K_SET_OWN = 2'd0,
        K_ACK     = 2'd1,
        K_REMOVE  = 2'd2,
        K_CLEAR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq;
    } t_cmd;

endpackage

@@ sv/qcss_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module qcss_front import qcss_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SLOT_W-1:0] i_slave_slot,
    input  logic [SEQ_W-1:0]  i_seq_value,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int NW = $clog2(CQ_DEPTH + 1);

    t_cmd          r_q [CQ_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    t_cmd          n_cmd;
    logic          w_wr;
    logic          w_rd;

    always_comb begin
        n_cmd.kind = t_kind'(i_kind);
        n_cmd.hit  = (int'(i_slave_slot) < MAX_REPLICAS);
        n_cmd.slot = i_slave_slot;
        n_cmd.seq  = i_seq_value;
    end

    assign o_full    = (r_cnt == NW'(CQ_DEPTH));
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_cmd_take && o_cmd_vld;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

@@ sv/qcss_back.sv @@
// Back end: slot table, sorted scan and quorum result register.
module qcss_back import qcss_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [QSIZE_W-1:0]   i_cfg_wdata,
    input  logic                 i_cmd_vld,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_take,
    output logic                 o_out_vld,
    input  logic                 i_pop,
    output logic [SEQ_W-1:0]     o_quorum_seq,
    output logic                 o_status,
    output logic [CNT_OUT_W-1:0] o_present_count
);

    localparam int AW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam int CW = $clog2(MAX_REPLICAS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    t_state                  r_state;
    logic [QSIZE_W-1:0]      r_qsize;
    logic [SEQ_W-1:0]        r_own;
    logic [MAX_REPLICAS-1:0] r_present;
    logic [SEQ_W-1:0]        r_mem [MAX_REPLICAS];
    logic [SEQ_W-1:0]        r_rd_data;
    logic                    r_rd_pres;
    logic [AW-1:0]           r_idx;
    logic [SEQ_W-1:0]        r_list [MAX_REPLICAS];
    logic [SEQ_W-1:0]        n_list [MAX_REPLICAS];
    logic [CW-1:0]           r_fill;
    logic [MAX_REPLICAS-1:0] w_ge;
    logic                    w_take;
    logic                    w_mem_we;
    logic                    w_load;
    logic [NEED_W-1:0]       w_need;
    logic [NEED_W-1:0]       w_need_m1;
    logic [SEQ_W-1:0]        w_sel;
    logic [SEQ_W-1:0]        n_seq;
    logic                    n_status;

    assign w_take     = (r_state == S_IDLE) && i_cmd_vld;
    assign o_cmd_take = w_take;
    assign w_mem_we   = w_take && (i_cmd.kind == K_ACK) && i_cmd.hit;
    assign w_load     = (r_state == S_RESULT) && (!o_out_vld || i_pop);

    // descending insertion of the slot read in the previous cycle
    always_comb begin
        for (int k = 0; k < MAX_REPLICAS; k++) begin
            w_ge[k] = (CW'(k) < r_fill) && (r_list[k] >= r_rd_data);
        end
        for (int k = 0; k < MAX_REPLICAS; k++) begin
            if (w_ge[k]) begin
                n_list[k] = r_list[k];
            end else if (k == 0) begin
                n_list[k] = r_rd_data;
            end else if (w_ge[k-1]) begin
                n_list[k] = r_rd_data;
            end else begin
                n_list[k] = r_list[k-1];
            end
        end
    end

    always_comb begin
        w_need    = r_qsize[QSIZE_W-1:1];
        w_need_m1 = w_need - 1'b1;
        w_sel     = '0;
        for (int k = 0; k < MAX_REPLICAS; k++) begin
            if (int'(w_need_m1) == k) begin
                w_sel = r_list[k];
            end
        end
        n_seq    = '0;
        n_status = 1'b0;
        if (w_need == '0) begin
            n_seq = r_own;
        end else if (int'(r_fill) < int'(w_need)) begin
            n_status = 1'b1;
        end else begin
            n_seq = w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qsize   <= QSIZE_RESET;
            r_own     <= '0;
            r_present <= '0;
            r_rd_pres <= 1'b0;
            r_idx     <= '0;
            r_fill    <= '0;
            o_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qsize <= i_cfg_wdata;
            end
            if (w_load) begin
                o_out_vld <= 1'b1;
            end else if (o_out_vld && i_pop) begin
                o_out_vld <= 1'b0;
            end
            r_rd_pres <= (r_state == S_SCAN) && r_present[r_idx];
            if (r_rd_pres) begin
                r_list <= n_list;
                r_fill <= r_fill + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        unique case (i_cmd.kind)
                            K_SET_OWN: r_own <= i_cmd.seq;
                            K_ACK: begin
                                if (i_cmd.hit) begin
                                    r_present[AW'(i_cmd.slot)] <= 1'b1;
                                end
                            end
                            K_REMOVE: begin
                                if (i_cmd.hit) begin
                                    r_present[AW'(i_cmd.slot)] <= 1'b0;
                                end
                            end
                            K_CLEAR: r_present <= '0;
                            default: r_own <= r_own;
                        endcase
                        r_idx   <= '0;
                        r_fill  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(MAX_REPLICAS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_load) begin
                        o_quorum_seq    <= n_seq;
                        o_status        <= n_status;
                        o_present_count <= CNT_OUT_W'(r_fill);
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[AW'(i_cmd.slot)] <= i_cmd.seq;
        end
        r_rd_data <= r_mem[r_idx];
    end

endmodule

@@ sv/quorum_commit_seq_select.sv @@
// Top level of the quorum commit sequence selector.
// Input queue: drive i_kind, i_slave_slot, i_seq_value and raise push; the
//   request is taken at a clock edge where push is high and full is low.
// Result queue: while empty is low, o_quorum_seq, o_status and
//   o_present_count show the oldest result; pop at an edge with empty low
//   takes it. Every request yields exactly one result, in order.
// Config: i_cfg_we with i_cfg_wdata writes quorum_size; write only while idle.
// A request passes the request queue, the back end's scan of the slot table,
//   its drain state and the result register before empty goes low.
// The back end takes the next request only once it has loaded the last
//   result, as it scans the slot table one entry per cycle through its
//   single read port while inserting into a sorted list.
// A two-entry request queue lets pushes continue while the back end works.
// When the receiver stalls, the finished result holds; the back end then
//   waits with the next result and the request queue fills and raises full.
// Reset clears all present marks, the own sequence and both queues, and
//   sets quorum_size to 3.
module quorum_commit_seq_select import qcss_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [SLOT_W-1:0]    i_slave_slot,
    input  logic [SEQ_W-1:0]     i_seq_value,
    input  logic                 i_cfg_we,
    input  logic [QSIZE_W-1:0]   i_cfg_wdata,
    output logic                 empty,
    input  logic                 pop,
    output logic [SEQ_W-1:0]     o_quorum_seq,
    output logic                 o_status,
    output logic [CNT_OUT_W-1:0] o_present_count
);

    t_cmd w_cmd;
    logic w_cmd_vld;
    logic w_cmd_take;
    logic w_out_vld;

    qcss_front #(.MAX_REPLICAS(MAX_REPLICAS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_kind       (i_kind),
        .i_slave_slot (i_slave_slot),
        .i_seq_value  (i_seq_value),
        .o_cmd_vld    (w_cmd_vld),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_cmd_take)
    );

    qcss_back #(.MAX_REPLICAS(MAX_REPLICAS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_vld       (w_cmd_vld),
        .i_cmd           (w_cmd),
        .o_cmd_take      (w_cmd_take),
        .o_out_vld       (w_out_vld),
        .i_pop           (pop),
        .o_quorum_seq    (o_quorum_seq),
        .o_status        (o_status),
        .o_present_count (o_present_count)
    );

    assign empty = !w_out_vld;

endmodule

@@ sv/qcss_checker.sv @@
// Port-level checker for the quorum sequence selector and its bind.
`include "quorum_commit_seq_select_assert.svh"

module qcss_checker import qcss_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic [SEQ_W-1:0]     o_quorum_seq,
    input logic                 o_status,
    input logic [CNT_OUT_W-1:0] o_present_count
);

    `QCSS_ASSERT_NOW(a_retry_zero, i_clk, i_rst_n, !empty && o_status, o_quorum_seq == '0)
    `QCSS_ASSERT_NOW(a_count_range, i_clk, i_rst_n, !empty, int'(o_present_count) <= MAX_REPLICAS)
    `QCSS_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_quorum_seq) && $stable(o_status) && $stable(o_present_count))

endmodule

bind quorum_commit_seq_select qcss_checker #(.MAX_REPLICAS(MAX_REPLICAS)) u_qcss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_quorum_seq    (o_quorum_seq),
    .o_status        (o_status),
    .o_present_count (o_present_count)
);

@@ tb/tb.sv @@
// Self-checking testbench for the quorum commit sequence selector.
module tb;
    import qcss_pkg::*;

    localparam int  MAX_SLOTS    = MAX_REPLICAS_DEF;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  RANDOM_SETS  = 25;
    localparam int  SET_SIZE     = 50;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RETRY = 1'b1;
    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    typedef struct packed {
        logic [SEQ_W-1:0]     seq;
        logic                 status;
        logic [CNT_OUT_W-1:0] count;
    } quorum_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [KIND_W-1:0]    i_kind = '0;
    logic [SLOT_W-1:0]    i_slave_slot = '0;
    logic [SEQ_W-1:0]     i_seq_value = '0;
    logic                 i_cfg_we = 1'b0;
    logic [QSIZE_W-1:0]   i_cfg_wdata = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [SEQ_W-1:0]     o_quorum_seq;
    logic                 o_status;
    logic [CNT_OUT_W-1:0] o_present_count;

    // model state
    logic                 slot_live_m [MAX_SLOTS];
    logic [SEQ_W-1:0]     slot_seq_m [MAX_SLOTS];
    logic [SEQ_W-1:0]     own_seq_m = '0;
    logic [QSIZE_W-1:0]   quorum_size_m = QSIZE_RESET;

    quorum_result_t commit_expect_q[$];
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  rx_hold_req = 0;

    quorum_commit_seq_select u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_slave_slot    (i_slave_slot),
        .i_seq_value     (i_seq_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .empty           (empty),
        .pop             (pop),
        .o_quorum_seq    (o_quorum_seq),
        .o_status        (o_status),
        .o_present_count (o_present_count)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        foreach (slot_live_m[i]) begin
            slot_live_m[i] = 1'b0;
            slot_seq_m[i]  = '0;
        end
    end

    // Apply one request to the model and return the result it must produce.
    function automatic quorum_result_t quorum_predict(t_kind kind, logic [SLOT_W-1:0] slot,
                                                      logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] ranked [MAX_SLOTS];
        logic [SEQ_W-1:0] v;
        int cnt;
        int k;
        int need;
        quorum_result_t r;
        case (kind)
            K_SET_OWN: begin
                own_seq_m = seq;
            end
            K_ACK: begin
                slot_live_m[slot] = 1'b1;
                slot_seq_m[slot]  = seq;
            end
            K_REMOVE: begin
                slot_live_m[slot] = 1'b0;
            end
            default: begin
                foreach (slot_live_m[i]) slot_live_m[i] = 1'b0;
            end
        endcase
        cnt = 0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (slot_live_m[i]) begin
                v = slot_seq_m[i];
                k = cnt;
                while (k > 0 && ranked[k-1] < v) begin
                    ranked[k] = ranked[k-1];
                    k--;
                end
                ranked[k] = v;
                cnt++;
            end
        end
        need     = quorum_size_m / 2;
        r.seq    = '0;
        r.status = STATUS_OK;
        r.count  = cnt[CNT_OUT_W-1:0];
        if (need == 0) begin
            r.seq = own_seq_m;
        end else if (cnt < need) begin
            r.status = STATUS_RETRY;
        end else begin
            r.seq = ranked[need-1];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        quorum_result_t want;
        if (i_rst_n && pop && !empty) begin
            if (commit_expect_q.size() == 0) begin
                $error("result with no request pending: quorum_seq %0d status %0d count %0d",
                       o_quorum_seq, o_status, o_present_count);
                err_cnt++;
            end else begin
                want = commit_expect_q.pop_front();
                if (o_quorum_seq !== want.seq) begin
                    $error("quorum_seq mismatch: expected %0d, actual %0d",
                           want.seq, o_quorum_seq);
                    err_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                    err_cnt++;
                end
                if (o_present_count !== want.count) begin
                    $error("present_count mismatch: expected %0d, actual %0d",
                           want.count, o_present_count);
                    err_cnt++;
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin : result_drain
        int stall_left;
        if (rx_hold_req > 0) begin
            stall_left  = rx_hold_req;
            rx_hold_req = 0;
        end
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(0, 2);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic logic [SEQ_W-1:0] rand_seq();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SEQ_MAX;
            2, 3, 4: return SEQ_W'($urandom_range(0, 7));
            5:       return SEQ_W'(1) << $urandom_range(0, SEQ_W - 1);
            default: return raw[SEQ_W-1:0];
        endcase
    endfunction

    function automatic t_kind rand_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 48)      return K_ACK;
        else if (p < 68) return K_SET_OWN;
        else if (p < 94) return K_REMOVE;
        else             return K_CLEAR;
    endfunction

    task automatic send_request(t_kind kind, logic [SLOT_W-1:0] slot, logic [SEQ_W-1:0] seq);
        @(negedge i_clk);
        push         <= 1'b1;
        i_kind       <= kind;
        i_slave_slot <= slot;
        i_seq_value  <= seq;
        do @(posedge i_clk); while (full);
        commit_expect_q.push_back(quorum_predict(kind, slot, seq));
    endtask

    task automatic idle_push(int n);
        repeat (n) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    task automatic tx_pause();
        if (tx_idle_en && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 15) == 0) idle_push($urandom_range(15, 40));
            else idle_push($urandom_range(1, 3));
        end
    endtask

    task automatic wait_drained();
        idle_push(1);
        while (commit_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_quorum_size(logic [QSIZE_W-1:0] qsize);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= qsize;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        quorum_size_m = qsize;
    endtask

    task automatic test_directed();
        // reset size 3 -> one ack needed; nothing present yet -> retry
        send_request(K_SET_OWN, SLOT_W'($urandom), SEQ_MAX);
        send_request(K_ACK, 3'd0, '0);
        send_request(K_ACK, 3'd1, SEQ_MAX);
        send_request(K_ACK, 3'd2, SEQ_W'(5));
        send_request(K_ACK, 3'd3, SEQ_W'(5));
        send_request(K_ACK, 3'd4, SEQ_W'(5));
        send_request(K_ACK, 3'd5, SEQ_W'(7));
        send_request(K_ACK, 3'd6, SEQ_W'(1));
        send_request(K_ACK, 3'd7, SEQ_MAX);
        set_quorum_size(5'd31);
        send_request(K_REMOVE, 3'd3, rand_seq());
        send_request(K_ACK, 3'd3, SEQ_W'(5));
        set_quorum_size(5'd6);
        send_request(K_ACK, 3'd6, SEQ_W'(5));
        send_request(K_ACK, 3'd5, SEQ_W'(3));
        send_request(K_REMOVE, 3'd1, rand_seq());
        send_request(K_REMOVE, 3'd1, rand_seq());
        set_quorum_size(5'd1);
        send_request(K_ACK, 3'd4, SEQ_W'(2));
        send_request(K_SET_OWN, 3'd7, '0);
        send_request(K_CLEAR, SLOT_W'($urandom), rand_seq());
        set_quorum_size(5'd2);
        send_request(K_SET_OWN, SLOT_W'($urandom), SEQ_W'(9));
        send_request(K_ACK, 3'd7, SEQ_W'(1));
        send_request(K_ACK, 3'd7, SEQ_MAX);
        send_request(K_CLEAR, SLOT_W'($urandom), rand_seq());
    endtask

    task automatic test_random_mix();
        logic [QSIZE_W-1:0] sizes [13] = '{5'd0, 5'd3, 5'd4, 5'd1, 5'd6, 5'd8, 5'd2,
                                           5'd17, 5'd31, 5'd5, 5'd16, 5'd7, 5'd9};
        for (int s = 0; s < RANDOM_SETS; s++) begin
            if (s < 13) set_quorum_size(sizes[s]);
            else if ($urandom_range(0, 5) == 0) set_quorum_size(QSIZE_W'($urandom_range(18, 31)));
            else set_quorum_size(QSIZE_W'($urandom_range(0, 17)));
            for (int n = 0; n < SET_SIZE; n++) begin
                tx_pause();
                send_request(rand_kind(), SLOT_W'($urandom), rand_seq());
            end
        end
    endtask

    task automatic test_back_to_back();
        set_quorum_size(QSIZE_W'($urandom_range(2, 9)));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (40) send_request(rand_kind(), SLOT_W'($urandom), rand_seq());
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_receiver_holdoff();
        set_quorum_size(QSIZE_W'($urandom_range(2, 7)));
        @(posedge i_clk);
        rx_hold_req = 300;
        tx_idle_en  = 1'b0;
        repeat (30) send_request(rand_kind(), SLOT_W'($urandom), rand_seq());
        tx_idle_en  = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_back_to_back();
        test_receiver_holdoff();
        wait_drained();
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
